// File: hw/rtl/two_moment_endpoint_transform_defines.svh
// ----------------------------------------------------------------------------
// Endpoint transform assertion macros
// Concurrent assertion wrappers, compiled away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TWO_MOMENT_ENDPOINT_TRANSFORM_DEFINES_SVH
`define TWO_MOMENT_ENDPOINT_TRANSFORM_DEFINES_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define TMET_ASSERT_SAME(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define TMET_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define TMET_ASSERT_SAME(label, pre, post)
`define TMET_ASSERT_NEXT(label, pre, post)
`endif
`endif

// File: hw/rtl/tmet_pkg.sv
// ----------------------------------------------------------------------------
// Endpoint transform package
// Word types, stage types, status codes and constants of the transform.
// ----------------------------------------------------------------------------
package tmet_pkg;

   // Fraction bits of the fixed-point inputs.
   localparam int FracBits = 16;
   // Reset value of the tolerance shift register.
   localparam logic [5:0] TolShiftReset = 6'd45;
   // Number of quotient bits produced by each divider lane.
   localparam int QuoBits = 31;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_EDGE      = 3'd1,
      STATUS_NEG_COUNT = 3'd2,
      STATUS_NOT_REAL  = 3'd3,
      STATUS_ZERO_MASS = 3'd4
   } status_type;

   typedef struct packed {
      logic signed [31:0] count_value;
      logic signed [31:0] mass_value;
      logic signed [31:0] edge_low;
      logic signed [31:0] edge_high;
   } req_word_type;

   typedef struct packed {
      logic [30:0] low_weight;
      logic [30:0] high_weight;
      logic [30:0] tolerance_out;
      logic        was_normalized;
      status_type  status;
   } rsp_word_type;

   // Products stage.
   typedef struct packed {
      logic signed [63:0] lo_c;
      logic signed [63:0] hi_c;
      logic signed [63:0] m_wide;
      logic [31:0]        den;
      logic               edge_bad;
      logic               count_neg;
      logic               count_zero;
      logic               mass_nonzero;
   } prod_stage_type;

   // Scale and numerator stage.
   typedef struct packed {
      logic [63:0]        scale;
      logic [63:0]        mass_mag;
      logic signed [63:0] low_num;
      logic signed [63:0] high_num;
      logic [31:0]        den;
      logic               edge_bad;
      logic               count_neg;
      logic               count_zero;
      logic               mass_nonzero;
   } sum_stage_type;

   // One restoring divider lane: partial remainder and the dividend bits
   // still to come, which turn into quotient bits as they shift out.
   typedef struct packed {
      logic [31:0]        rem;
      logic [QuoBits-1:0] word;
      logic               sat;
   } div_lane_type;

   typedef struct packed {
      div_lane_type [2:0] lane;
      logic [31:0]        den;
      logic               norm;
      status_type         status;
   } div_stage_type;

   // Magnitude of a signed 64-bit value.
   function automatic logic [63:0] mag64(logic signed [63:0] x);
      logic [63:0] res;
      res = x[63] ? 64'(-x) : 64'(x);
      return res;
   endfunction

   // One step of restoring division.
   function automatic div_lane_type div_step(div_lane_type lane, logic [31:0] den);
      logic [32:0]  trial;
      div_lane_type nxt;
      trial = {lane.rem, lane.word[QuoBits-1]};
      nxt   = lane;
      if (trial >= {1'b0, den}) begin
         nxt.rem  = 32'(trial - {1'b0, den});
         nxt.word = {lane.word[QuoBits-2:0], 1'b1};
      end else begin
         nxt.rem  = trial[31:0];
         nxt.word = {lane.word[QuoBits-2:0], 1'b0};
      end
      return nxt;
   endfunction

endpackage

// File: hw/rtl/two_moment_endpoint_transform.sv
// ----------------------------------------------------------------------------
// Two-moment endpoint transform
// Splits a bin's count and mass into weights at both edges, with a tolerance
// divided by the bin width (one at zero count) and a status code for invalid bins.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Word
// req       in         req_valid / req_ready   req_data (count, mass, edges)
// rsp       out        rsp_valid / rsp_ready   rsp_data (weights, tol, status)
// csr       in         csr_valid / csr_ready   csr_data (tolerance shift)
//
// One word enters per cycle while rsp is not stalled; each word passes a multiply
// stage, a sum stage, a check stage and 31 restoring divider stages.
// A stall on rsp freezes the whole pipeline; nothing is lost or repeated.
// Reset clears the valid bits and loads the tolerance shift with 45.
// The csr port is always ready and the shift applies to words checked later.
// ----------------------------------------------------------------------------
module two_moment_endpoint_transform
   import tmet_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [5:0]   csr_data
);
`include "two_moment_endpoint_transform_defines.svh"

   localparam int DivLast = QuoBits;

   logic [5:0]     shift_ff;
   logic           advance;
   logic           prod_valid_ff;
   prod_stage_type prod_ff;
   prod_stage_type prod_in;
   logic           sum_valid_ff;
   sum_stage_type  sum_ff;
   sum_stage_type  sum_in;
   logic           div_valid_ff [0:DivLast];
   div_stage_type  div_ff [0:DivLast];
   div_stage_type  div_in;
   logic           rsp_err;
   logic           rsp_blank;

   // The pipeline moves whenever the output word is absent or taken.
   assign advance   = !div_valid_ff[DivLast] || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   // Tolerance shift register.
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= TolShiftReset;
      end else if (csr_valid) begin
         shift_ff <= csr_data;
      end
   end

   // Products and input checks.
   always_comb begin
      prod_in.lo_c         = 64'(req_data.edge_low) * 64'(req_data.count_value);
      prod_in.hi_c         = 64'(req_data.edge_high) * 64'(req_data.count_value);
      prod_in.m_wide       = 64'(req_data.mass_value) <<< FracBits;
      prod_in.den          = 32'(req_data.edge_high - req_data.edge_low);
      prod_in.edge_bad     = !(req_data.edge_low < req_data.edge_high);
      prod_in.count_neg    = req_data.count_value[31];
      prod_in.count_zero   = (req_data.count_value == 32'sd0);
      prod_in.mass_nonzero = (req_data.mass_value != 32'sd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else if (advance) begin
         prod_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
      end
   end

   // Magnitude scale and the two numerators.
   always_comb begin
      sum_in.mass_mag     = mag64(prod_ff.m_wide);
      sum_in.scale        = sum_in.mass_mag + mag64(prod_ff.lo_c) + mag64(prod_ff.hi_c);
      sum_in.low_num      = prod_ff.hi_c - prod_ff.m_wide;
      sum_in.high_num     = prod_ff.m_wide - prod_ff.lo_c;
      sum_in.den          = prod_ff.den;
      sum_in.edge_bad     = prod_ff.edge_bad;
      sum_in.count_neg    = prod_ff.count_neg;
      sum_in.count_zero   = prod_ff.count_zero;
      sum_in.mass_nonzero = prod_ff.mass_nonzero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else if (advance) begin
         sum_valid_ff <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sum_ff <= sum_in;
      end
   end

   // Tolerance, status checks and divider setup. A zero count divides the
   // tolerance by one in fixed point, which is the plain shift down.
   always_comb begin
      logic [63:0] tol;
      logic        not_real;
      logic [63:0] num [0:2];
      logic [31:0] den;
      logic        err;
      tol      = sum_ff.scale >> shift_ff;
      not_real = (sum_ff.low_num[63] && (mag64(sum_ff.low_num) > tol)) ||
                 (sum_ff.high_num[63] && (mag64(sum_ff.high_num) > tol));
      if (sum_ff.edge_bad) begin
         div_in.status = STATUS_EDGE;
      end else if (sum_ff.count_neg) begin
         div_in.status = STATUS_NEG_COUNT;
      end else if (not_real) begin
         div_in.status = STATUS_NOT_REAL;
      end else if (sum_ff.count_zero && (sum_ff.mass_mag > tol)) begin
         div_in.status = STATUS_ZERO_MASS;
      end else begin
         div_in.status = STATUS_OK;
      end
      err = (div_in.status != STATUS_OK);
      if (sum_ff.count_zero) begin
         num[0]      = '0;
         num[1]      = '0;
         den         = 32'(1) << FracBits;
         div_in.norm = sum_ff.mass_nonzero;
      end else begin
         num[0]      = sum_ff.low_num[63] ? 64'd0 : 64'(sum_ff.low_num);
         num[1]      = sum_ff.high_num[63] ? 64'd0 : 64'(sum_ff.high_num);
         den         = sum_ff.den;
         div_in.norm = sum_ff.low_num[63] || sum_ff.high_num[63];
      end
      num[2] = tol;
      // An invalid bin runs zero through the dividers.
      if (err) begin
         num[0]      = '0;
         num[1]      = '0;
         num[2]      = '0;
         den         = 32'd1;
         div_in.norm = 1'b0;
      end
      div_in.den = den;
      for (int i = 0; i < 3; i++) begin
         div_in.lane[i].sat  = (num[i][63:QuoBits] >= {1'b0, den});
         div_in.lane[i].rem  = num[i][QuoBits+31:QuoBits];
         div_in.lane[i].word = num[i][QuoBits-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid_ff[0] <= 1'b0;
      end else if (advance) begin
         div_valid_ff[0] <= sum_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         div_ff[0] <= div_in;
      end
   end

   // Divider stages, one quotient bit per lane in each.
   for (genvar k = 1; k <= DivLast; k++) begin : g_div
      div_stage_type step_in;

      always_comb begin
         step_in = div_ff[k-1];
         for (int i = 0; i < 3; i++) begin
            step_in.lane[i] = div_step(div_ff[k-1].lane[i], div_ff[k-1].den);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_valid_ff[k] <= 1'b0;
         end else if (advance) begin
            div_valid_ff[k] <= div_valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            div_ff[k] <= step_in;
         end
      end
   end

   // Result word with saturation.
   assign rsp_valid = div_valid_ff[DivLast];
   always_comb begin
      rsp_data.low_weight     = div_ff[DivLast].lane[0].sat ? '1 : div_ff[DivLast].lane[0].word;
      rsp_data.high_weight    = div_ff[DivLast].lane[1].sat ? '1 : div_ff[DivLast].lane[1].word;
      rsp_data.tolerance_out  = div_ff[DivLast].lane[2].sat ? '1 : div_ff[DivLast].lane[2].word;
      rsp_data.was_normalized = div_ff[DivLast].norm;
      rsp_data.status         = div_ff[DivLast].status;
   end

   // Error and empty-payload conditions of the output word.
   assign rsp_err   = rsp_valid && (rsp_data.status != STATUS_OK);
   assign rsp_blank = (rsp_data.low_weight == '0) && (rsp_data.high_weight == '0) &&
                      (rsp_data.tolerance_out == '0) && !rsp_data.was_normalized;

   // An error word carries no weights, tolerance or clamp flag.
   `TMET_ASSERT_SAME(a_err_zero, rsp_err, rsp_blank)
   // A stalled result is held by the frozen pipeline.
   `TMET_ASSERT_NEXT(a_stall_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   // A register write lands in the shift register.
   `TMET_ASSERT_NEXT(a_csr_write, csr_valid && csr_ready, shift_ff == $past(csr_data))

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// Endpoint transform testbench
// Streams directed and random bins through the transform under random idling
// on both sides, predicts each result word in place and checks it field by
// field against the words that leave the block.
// ----------------------------------------------------------------------------
module testbench;
   import tmet_pkg::*;

   localparam int Latency = 40;
   localparam int CycleLimit = 400000;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_word_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_word_type rsp_data;
   logic         csr_valid;
   logic         csr_ready;
   logic [5:0]   csr_data;

   req_word_type pending_bins[$];
   rsp_word_type expected_words[$];
   logic [5:0]   shift_setting;
   int           mismatch_count = 0;
   int           cycle_count = 0;
   int           send_gap;
   int           hold_cycles;
   bit           sender_pause;
   bit           long_hold_request;

   two_moment_endpoint_transform uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Magnitude of a 64-bit signed value.
   function automatic logic [63:0] magnitude(logic signed [63:0] x);
      return x[63] ? 64'(-x) : 64'(x);
   endfunction

   function automatic logic [30:0] clip31(logic [63:0] x);
      return (x > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : x[30:0];
   endfunction

   // Predicts the endpoint weights, tolerance and status of one bin.
   function automatic rsp_word_type endpoint_weights(req_word_type b, logic [5:0] sh);
      rsp_word_type       r;
      logic signed [63:0] c, m_wide, lo_c, hi_c, low_num, high_num;
      logic [63:0]        scale, tol, den;
      r = '0;
      r.status = STATUS_OK;
      c = b.count_value;
      m_wide = 64'(signed'(b.mass_value)) <<< FracBits;
      lo_c = 64'(signed'(b.edge_low)) * c;
      hi_c = 64'(signed'(b.edge_high)) * c;
      if (!(b.edge_low < b.edge_high)) begin
         r.status = STATUS_EDGE;
         return r;
      end
      if (c < 0) begin
         r.status = STATUS_NEG_COUNT;
         return r;
      end
      scale = magnitude(m_wide) + magnitude(lo_c) + magnitude(hi_c);
      tol = scale >> sh;
      low_num = hi_c - m_wide;
      high_num = m_wide - lo_c;
      if ((low_num < 0 && magnitude(low_num) > tol) ||
          (high_num < 0 && magnitude(high_num) > tol)) begin
         r.status = STATUS_NOT_REAL;
         return r;
      end
      if (c == 0) begin
         if (magnitude(m_wide) > tol) begin
            r.status = STATUS_ZERO_MASS;
            return r;
         end
         r.tolerance_out = clip31(tol >> FracBits);
         r.was_normalized = (b.mass_value != 0);
      end else begin
         den = 64'(64'(signed'(b.edge_high)) - 64'(signed'(b.edge_low)));
         if (low_num < 0) r.was_normalized = 1'b1;
         else r.low_weight = clip31(64'(low_num) / den);
         if (high_num < 0) r.was_normalized = 1'b1;
         else r.high_weight = clip31(64'(high_num) / den);
         r.tolerance_out = clip31(tol / den);
      end
      return r;
   endfunction

   function automatic req_word_type make_bin(int c, int m, int lo, int hi);
      req_word_type b;
      b.count_value = c;
      b.mass_value = m;
      b.edge_low = lo;
      b.edge_high = hi;
      return b;
   endfunction

   // Mostly well-formed bins: increasing edges, nonnegative count, mass between
   // lower*C and upper*C; the rest is raw noise or edge cases.
   function automatic req_word_type random_bin();
      req_word_type b;
      int           lo, w, c, frac;
      longint       m;
      b = {$urandom, $urandom, $urandom, $urandom};
      if ($urandom_range(0, 9) < 7) begin
         lo = $urandom_range(0, 1) ? int'($urandom_range(0, 2000000)) - 1000000 :
              int'($urandom);
         if (lo > 2000000000) lo = lo - 500000000;
         w = $urandom_range(1, $urandom_range(0, 1) ? 200000 : 100000000);
         c = $urandom_range(0, 5) == 0 ? 0 : $urandom_range(0, $urandom_range(1, 1 << 20));
         frac = $urandom_range(0, 1000);
         m = ((longint'(lo) * c) + (longint'(w) * c * frac) / 1000) >>> FracBits;
         m = m + $urandom_range(0, 4) - 2;
         b.count_value = c;
         b.mass_value = int'(m);
         b.edge_low = lo;
         b.edge_high = lo + w;
      end else if ($urandom_range(0, 1)) begin
         b.count_value = $urandom_range(0, 3) == 0 ? 0 : b.count_value;
      end
      return b;
   endfunction

   // Appends one bin to the queue of pending bins.
   task automatic add_bin(req_word_type b);
      pending_bins = {pending_bins, b};
   endtask

   // Drives the request channel from the queue of pending bins.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
         send_gap <= 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_words = {expected_words, endpoint_weights(req_data, shift_setting)};
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_bins.size() > 0 && !sender_pause) begin
               req_valid <= 1'b1;
               req_data <= pending_bins.pop_front();
               send_gap <= $urandom_range(0, 3) != 0 ? 0 :
                           ($urandom_range(0, 9) == 0 ? $urandom_range(10, 60) :
                                                        $urandom_range(1, 3));
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver idling, with occasional long hold-offs counted here.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_cycles <= 0;
      end else if (long_hold_request && hold_cycles == 0) begin
         hold_cycles <= 150;
         rsp_ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= (hold_cycles == 1);
      end else if ($urandom_range(0, 49) == 0) begin
         hold_cycles <= $urandom_range(10, 40);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= $urandom_range(0, 3) != 0;
      end
   end

   // Checks each accepted result word against the oldest prediction.
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10) $display("unexpected word %h", rsp_data);
         end else begin
            want = expected_words.pop_front();
            if (rsp_data.low_weight !== want.low_weight ||
                rsp_data.high_weight !== want.high_weight ||
                rsp_data.tolerance_out !== want.tolerance_out ||
                rsp_data.was_normalized !== want.was_normalized ||
                rsp_data.status !== want.status) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10)
                  $display("exp L %h H %h T %h N %b S %0d, got L %h H %h T %h N %b S %0d",
                     want.low_weight, want.high_weight, want.tolerance_out,
                     want.was_normalized, want.status, rsp_data.low_weight,
                     rsp_data.high_weight, rsp_data.tolerance_out,
                     rsp_data.was_normalized, rsp_data.status);
            end
         end
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   // Writes the tolerance shift while the block is idle.
   task automatic write_shift(logic [5:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      shift_setting = value;
   endtask

   task automatic drain_all();
      while (pending_bins.size() > 0 || req_valid || expected_words.size() > 0)
         @(posedge clock);
      repeat (Latency) @(posedge clock);
   endtask

   task automatic random_phase(int count);
      repeat (count) add_bin(random_bin());
      drain_all();
   endtask

   initial begin
      shift_setting = TolShiftReset;
      sender_pause = 1'b0;
      long_hold_request = 1'b0;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_data = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed bins: field extremes, the edge, count and not-real statuses, clamps, zero count.
      add_bin(make_bin(65536, 98304, 65536, 131072));
      add_bin(make_bin(65536, 0, 131072, 131072));
      add_bin(make_bin(65536, 0, 131072, 65536));
      add_bin(make_bin(-65536, 98304, 65536, 131072));
      add_bin(make_bin(32'h8000_0000, 0, 0, 1));
      add_bin(make_bin(65536, 500000, 65536, 131072));
      add_bin(make_bin(65536, 10, 65536, 131072));
      add_bin(make_bin(0, 65536, 0, 65536));
      add_bin(make_bin(0, 0, 0, 65536));
      add_bin(make_bin(65536, 65536, 65536, 131072));
      add_bin(make_bin(65536, 131072, 65536, 131072));
      add_bin(make_bin(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
      add_bin(make_bin(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
      add_bin(make_bin(32'h7FFF_FFFF, 0, 32'h7FFF_FFFE, 32'h7FFF_FFFF));
      add_bin(make_bin(1, 0, -1, 1));
      add_bin(make_bin(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      drain_all();

      // Tolerance shift at its extremes, zero count with small mass passes.
      write_shift(6'd0);
      add_bin(make_bin(0, 5, 0, 65536));
      add_bin(make_bin(65536, 200000, 65536, 131072));
      random_phase(60);
      write_shift(6'd63);
      random_phase(60);

      // Long receiver hold-off while the sender keeps offering words.
      write_shift(6'd20);
      long_hold_request = 1'b1;
      repeat (100) add_bin(random_bin());
      @(posedge clock);
      while (hold_cycles <= 100) @(posedge clock);
      long_hold_request = 1'b0;
      drain_all();

      // Sender pauses until every expected word has come back.
      write_shift(6'd45);
      repeat (40) add_bin(random_bin());
      repeat (20) @(posedge clock);
      sender_pause = 1'b1;
      while (req_valid || expected_words.size() > 0) @(posedge clock);
      sender_pause = 1'b0;
      drain_all();
      write_shift(6'd31);
      random_phase(80);
      write_shift(6'd8);
      random_phase(60);

      if (mismatch_count == 0 && expected_words.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/tmet_pkg.sv
hw/rtl/two_moment_endpoint_transform.sv
bench/testbench.sv
